@@ hdl/stm_pkg.sv @@
// stm_pkg: shared types, codes and lookup tables for the scrolled tilemap layer.
// No dependencies; imported by every module of the block.
`default_nettype none

package stm_pkg;

  // Request kinds carried on the input channel
  typedef enum logic [1:0] {
    ACT_MAP_WR = 2'd0,
    ACT_PEN_WR = 2'd1,
    ACT_PIXEL  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Configuration register slots (byte address = 4 * slot)
  typedef enum logic [1:0] {
    REG_LAYOUT   = 2'd0,
    REG_SCROLL_X = 2'd1,
    REG_SCROLL_Y = 2'd2,
    REG_LAYER_EN = 2'd3
  } reg_idx_t;

  localparam int unsigned TILE_CODES      = 2048;
  localparam int unsigned ROW_OFFSET      = 16;
  localparam logic [3:0]  PEN_TRANSPARENT = 4'hf;

  localparam logic [15:0] GROUP_MASK [4] = '{16'hffff, 16'hfff0, 16'hff00, 16'hf000};
  localparam logic [1:0]  COLOUR_GROUP [16] = '{
    2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
  };

  typedef struct packed {
    logic [1:0]  action;
    logic [12:0] map_index;
    logic [15:0] map_word;
    logic [18:0] pen_address;
    logic [3:0]  pen_value;
    logic [7:0]  screen_x;
    logic [7:0]  view_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] palette_index;
    logic       back_opaque;
    logic       front_opaque;
  } out_item_t;

  // Classified request as it sits in the queue
  typedef struct packed {
    action_t     kind;
    logic [12:0] map_addr;
    logic [15:0] map_word;
    logic [18:0] pen_addr;
    logic [3:0]  pen_value;
    logic [3:0]  pix_x;
    logic [3:0]  pix_y;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Pen shows in the front half when its bit is clear in the group mask
  function automatic logic pen_in_front(input logic [3:0] colour, input logic [3:0] pen);
    logic [1:0]  grp;
    logic [15:0] msk;
    grp = COLOUR_GROUP[colour];
    msk = GROUP_MASK[grp];
    return ~msk[pen];
  endfunction

endpackage

`default_nettype wire

@@ hdl/stm_front.sv @@
// stm_front: classifies requests and resolves scrolled pixel position to a map entry.
// Depends on stm_pkg.
`default_nettype none

module stm_front
  import stm_pkg::*;
(
  input  in_item_t    item,
  input  logic        layout_wide,
  input  logic [15:0] scroll_x,
  input  logic [15:0] scroll_y,
  output job_t        job,
  output logic        job_keep
);

  logic [8:0]  row;
  logic [10:0] sum_x;
  logic [10:0] sum_y;
  logic [10:0] mx;
  logic [10:0] my;
  logic [6:0]  col_t;
  logic [6:0]  row_t;
  logic [12:0] scan;
  action_t     kind;

  always_comb begin
    kind  = action_t'(item.action);
    row   = {1'b0, item.view_row} + 9'(ROW_OFFSET);
    sum_x = scroll_x[10:0] + {3'b000, item.screen_x};
    sum_y = scroll_y[10:0] + {2'b00, row};
    // wide map is 2048x1024, tall map 1024x2048
    mx    = layout_wide ? sum_x : {1'b0, sum_x[9:0]};
    my    = layout_wide ? {1'b0, sum_y[9:0]} : sum_y;
    col_t = mx[10:4];
    row_t = my[10:4];
    if (layout_wide) begin
      scan = {row_t[5:4], col_t[6:4], row_t[3:0], col_t[3:0]};
    end else begin
      scan = {row_t[6:4], col_t[5:4], row_t[3:0], col_t[3:0]};
    end

    job.kind      = kind;
    job.map_addr  = (kind == ACT_PIXEL) ? scan : item.map_index;
    job.map_word  = item.map_word;
    job.pen_addr  = item.pen_address;
    job.pen_value = item.pen_value;
    job.pix_x     = mx[3:0];
    job.pix_y     = my[3:0];
    job_keep      = (kind != ACT_NONE);
  end

endmodule

`default_nettype wire

@@ hdl/stm_queue.sv @@
// stm_queue: short request queue between front and back halves.
// Depends on stm_pkg.
`default_nettype none

module stm_queue
  import stm_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_data,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ hdl/stm_back.sv @@
// stm_back: executes queued requests: tile map stage, pen stage, result register.
// Depends on stm_pkg; holds the tile map and pen store memories.
`default_nettype none

module stm_back
  import stm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head,
  input  q_stat_t   stat,
  output logic      pop,
  input  logic      layer_en,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data
);

  logic [15:0] tile_mem [8192];
  logic [3:0]  pen_mem  [524288];

  logic        adv;
  logic        a_go;

  // tile map stage
  logic        a_v_r;
  action_t     a_kind_r;
  logic [18:0] a_pen_addr_r;
  logic [3:0]  a_pen_val_r;
  logic [3:0]  a_px_r;
  logic [3:0]  a_py_r;
  logic [15:0] tile_q_r;

  // pen stage
  logic        b_v_r;
  action_t     b_kind_r;
  logic [3:0]  b_colour_r;
  logic [3:0]  pen_q_r;

  logic        out_valid_r;
  out_item_t   out_data_r;

  logic [10:0] code;
  logic [3:0]  colour;
  logic [3:0]  px_eff;
  logic [18:0] pen_rd_addr;

  assign adv  = !out_valid_r || out_ready;
  assign pop  = adv && !stat.empty;
  assign a_go = adv && a_v_r;

  always_comb begin
    code        = {tile_q_r[10:8], tile_q_r[7:0]} & 11'(TILE_CODES - 1);
    colour      = tile_q_r[14:11];
    px_eff      = tile_q_r[15] ? ~a_px_r : a_px_r;
    pen_rd_addr = {code, a_py_r, px_eff};
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.kind == ACT_MAP_WR) begin
        tile_mem[head.map_addr] <= head.map_word;
      end
      tile_q_r <= tile_mem[head.map_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      if (a_kind_r == ACT_PEN_WR) begin
        pen_mem[a_pen_addr_r] <= a_pen_val_r;
      end
      pen_q_r <= pen_mem[pen_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_v_r       <= pop;
      b_v_r       <= a_v_r;
      out_valid_r <= b_v_r && (b_kind_r == ACT_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind_r                 <= head.kind;
      a_pen_addr_r             <= head.pen_addr;
      a_pen_val_r              <= head.pen_value;
      a_px_r                   <= head.pix_x;
      a_py_r                   <= head.pix_y;
      b_kind_r                 <= a_kind_r;
      b_colour_r               <= colour;
      out_data_r.palette_index <= {b_colour_r, pen_q_r};
      out_data_r.back_opaque   <= layer_en && (pen_q_r != PEN_TRANSPARENT);
      out_data_r.front_opaque  <= layer_en && pen_in_front(b_colour_r, pen_q_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ hdl/scrolled_tilemap_pixel_priority.sv @@
// scrolled_tilemap_pixel_priority: top level of the scrolling background layer.
// Depends on stm_pkg, stm_front, stm_queue, stm_back.
//
//  port group | direction | handshake             | payload
//  -----------+-----------+-----------------------+---------------------------------
//  in_*       | into      | in_valid / in_ready   | in_item_t: map/pen write or pixel
//  out_*      | out of    | out_valid / out_ready | out_item_t: palette index, opacity
//  APB        | into      | psel/penable, pready=1| four config regs at 0x0..0xc
//
// One request per clock sustained while out_ready stays high; an accepted pixel
// goes through the queue slot, tile map read, pen read and result register to out_valid.
// Rate is set by the single access per clock on each of the two memories.
// rst_n is synchronous: it clears the queue, the stage valids and the config regs
// except layer enable, which it sets; the memories are not cleared and hold garbage
// until written. When a result is held with out_ready low the back half freezes;
// the queue soaks up the front half and in_ready drops once it is full.
`default_nettype none

module scrolled_tilemap_pixel_priority
  import stm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // config registers
  logic        layout_r;
  logic [15:0] scroll_x_r;
  logic [15:0] scroll_y_r;
  logic        layer_en_r;
  logic        cfg_wr;
  reg_idx_t    cfg_sel;

  job_t        job;
  logic        job_keep;
  logic        q_push;
  logic        q_pop;
  job_t        q_head;
  q_stat_t     q_stat;

  assign pready  = 1'b1;
  assign cfg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r   <= 1'b0;
      scroll_x_r <= '0;
      scroll_y_r <= '0;
      layer_en_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_LAYOUT:   layout_r   <= pwdata[0];
        REG_SCROLL_X: scroll_x_r <= pwdata[15:0];
        REG_SCROLL_Y: scroll_y_r <= pwdata[15:0];
        REG_LAYER_EN: layer_en_r <= pwdata[0];
        default:      layout_r   <= layout_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_LAYOUT:   prdata = {31'd0, layout_r};
      REG_SCROLL_X: prdata = {16'd0, scroll_x_r};
      REG_SCROLL_Y: prdata = {16'd0, scroll_y_r};
      REG_LAYER_EN: prdata = {31'd0, layer_en_r};
      default:      prdata = '0;
    endcase
  end

  // Front: position math and scan-order mapping, straight into the queue.
  // Unused action codes are accepted and dropped here.
  stm_front u_front (
    .item        (in_data),
    .layout_wide (layout_r),
    .scroll_x    (scroll_x_r),
    .scroll_y    (scroll_y_r),
    .job         (job),
    .job_keep    (job_keep)
  );

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready && job_keep;

  stm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (job),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // Back: memory accesses in request order, so writes are seen by later pixels.
  stm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .stat      (q_stat),
    .pop       (q_pop),
    .layer_en  (layer_en_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ hdl/stm_checker.sv @@
// stm_checker: port-level assertions for the scrolled tilemap layer, bound to the top.
// Depends on stm_pkg and scrolled_tilemap_pixel_priority.
`default_nettype none

module stm_checker
  import stm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire out_item_t   out_data,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [3:0]  paddr,
  input wire logic [31:0] pwdata
);

  // shadow of the layer enable register, tracked from the config port
  logic en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1;
    end else if (psel && penable && pwrite && (reg_idx_t'(paddr[3:2]) == REG_LAYER_EN)) begin
      en_r <= pwdata[0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_front_needs_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.front_opaque |-> out_data.back_opaque)
    else $error("front opaque on a transparent pen");

  a_disabled_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !en_r |-> !out_data.back_opaque && !out_data.front_opaque)
    else $error("opacity set with layer disabled");

  a_back_matches_pen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && en_r |-> out_data.back_opaque == (out_data.palette_index[3:0] != PEN_TRANSPARENT))
    else $error("back opacity disagrees with pen");

endmodule

bind scrolled_tilemap_pixel_priority stm_checker u_stm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata)
);

`default_nettype wire

@@ tb/sv/scrolled_tilemap_pixel_priority_tb.sv @@
// Self-checking testbench for the scrolled tilemap pixel priority layer.
// Depends on stm_pkg and scrolled_tilemap_pixel_priority; drives requests,
// APB configuration writes and random back-pressure, and checks every pixel.
module scrolled_tilemap_pixel_priority_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stm_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;  // generous bound for the slowest legal run
  localparam int TRAFFIC_REQS = 1400;    // random requests across all idling phases
  localparam int CHUNKS       = 4;       // config settings per idling phase
  localparam int DRAIN_CYCLES = 8;       // pipeline is 3 deep; writes leave no trace
  localparam int REPORT_LIMIT = 10;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the block: tile map and pen store hold only written entries,
  // so exists() tells which entries a pixel request may legally touch.
  logic [15:0] tile_words [int];
  logic [3:0]  pen_values [int];
  logic        cfg_wide     = 1'b0;
  logic [15:0] cfg_scroll_x = '0;
  logic [15:0] cfg_scroll_y = '0;
  logic        cfg_enable   = 1'b1;

  out_item_t   pending_pixels [$];   // predicted pixels, oldest first
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          errors       = 0;
  int          requests_sent = 0;    // accepted requests, ignored action excluded

  scrolled_tilemap_pixel_priority u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Screen position -> tile map slot plus pixel inside the 16x16 tile.
  // Wide map is 2048x1024, tall map 1024x2048; the visible row starts 16 lines down.
  function automatic void locate(input logic [7:0] sx, input logic [7:0] sy,
                                 output logic [12:0] slot, output logic [3:0] px,
                                 output logic [3:0] py);
    logic [10:0] mx;
    logic [10:0] my;
    logic [6:0]  col;
    logic [6:0]  row;
    mx = 11'(sx + cfg_scroll_x);
    my = 11'(sy + ROW_OFFSET + cfg_scroll_y);
    if (cfg_wide) begin
      my[10] = 1'b0;
    end else begin
      mx[10] = 1'b0;
    end
    col = mx[10:4];
    row = my[10:4];
    px  = mx[3:0];
    py  = my[3:0];
    // Page scan: 16x16 tiles per page, pages laid out 8x4 (wide) or 4x8 (tall)
    if (cfg_wide) begin
      slot = {row[5:4], col[6:4], row[3:0], col[3:0]};
    end else begin
      slot = {row[6:4], col[5:4], row[3:0], col[3:0]};
    end
  endfunction

  // Pen entry for a pixel of the tile held in word: code, row, column (mirrored on flip)
  function automatic logic [18:0] pen_slot(input logic [15:0] word, input logic [3:0] px,
                                           input logic [3:0] py);
    return {word[10:0], py, word[15] ? 4'd15 - px : px};
  endfunction

  function automatic out_item_t shade_pixel(input logic [7:0] sx, input logic [7:0] sy);
    logic [12:0] slot;
    logic [3:0]  px;
    logic [3:0]  py;
    logic [15:0] word;
    logic [3:0]  colour;
    logic [3:0]  pen;
    int          front_limit;
    out_item_t   res;
    locate(sx, sy, slot, px, py);
    word   = tile_words[slot];
    pen    = pen_values[pen_slot(word, px, py)];
    colour = word[14:11];
    // Colour pairs 0/1, 2/3, 4/5 put pens below 12, 8, 4 in front; 6..15 never
    case (colour[3:1])
      3'd0:    front_limit = 12;
      3'd1:    front_limit = 8;
      3'd2:    front_limit = 4;
      default: front_limit = 0;
    endcase
    res.palette_index = {colour, pen};
    res.back_opaque   = cfg_enable && (pen != PEN_TRANSPARENT);
    res.front_opaque  = cfg_enable && (int'(pen) < front_limit);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Every field random; the caller overrides the ones that matter
  function automatic in_item_t random_item(input action_t kind);
    in_item_t it;
    it.action      = kind;
    it.map_index   = 13'($urandom);
    it.map_word    = 16'($urandom);
    it.pen_address = 19'($urandom);
    it.pen_value   = 4'($urandom);
    it.screen_x    = 8'($urandom);
    it.view_row    = 8'($urandom);
    return it;
  endfunction

  // Called at a rising edge; returns at the edge that accepted the request.
  // Valid stays high across back-to-back requests.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (action_t'(it.action))
      ACT_MAP_WR: tile_words[it.map_index]   = it.map_word;
      ACT_PEN_WR: pen_values[it.pen_address] = it.pen_value;
      ACT_PIXEL:  pending_pixels.push_back(shade_pixel(it.screen_x, it.view_row));
      default:    ;
    endcase
    if (action_t'(it.action) != ACT_NONE) requests_sent++;
  endtask

  task automatic write_tile_at(input logic [7:0] sx, input logic [7:0] sy,
                               input logic [15:0] word);
    in_item_t    it;
    logic [12:0] slot;
    logic [3:0]  px;
    logic [3:0]  py;
    locate(sx, sy, slot, px, py);
    it = random_item(ACT_MAP_WR);
    it.map_index = slot;
    it.map_word  = word;
    send_item(it);
  endtask

  // Writes the pen this screen position reads; fills in the tile first if needed
  task automatic write_pen_at(input logic [7:0] sx, input logic [7:0] sy,
                              input logic [3:0] value);
    in_item_t    it;
    logic [12:0] slot;
    logic [3:0]  px;
    logic [3:0]  py;
    locate(sx, sy, slot, px, py);
    if (!tile_words.exists(slot)) write_tile_at(sx, sy, 16'($urandom));
    it = random_item(ACT_PEN_WR);
    it.pen_address = pen_slot(tile_words[slot], px, py);
    it.pen_value   = value;
    send_item(it);
  endtask

  // Pixel request; the stores never get read where nothing was written
  task automatic fetch_pixel(input logic [7:0] sx, input logic [7:0] sy);
    in_item_t    it;
    logic [12:0] slot;
    logic [3:0]  px;
    logic [3:0]  py;
    locate(sx, sy, slot, px, py);
    if (!tile_words.exists(slot) || !pen_values.exists(pen_slot(tile_words[slot], px, py)))
      write_pen_at(sx, sy, 4'($urandom));
    it = random_item(ACT_PIXEL);
    it.screen_x = sx;
    it.view_row = sy;
    send_item(it);
  endtask

  // Let every pixel come back and any trailing writes retire, receiver fully open
  task automatic wait_idle();
    int saved_stall;
    saved_stall  = rx_stall_pct;
    rx_stall_pct = 0;
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    rx_stall_pct = saved_stall;
  endtask

  // APB write: setup phase, then access phase; lands when pready is seen high.
  // The bus is returned to idle before the task returns.
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LAYOUT:   cfg_wide     = data[0];
      REG_SCROLL_X: cfg_scroll_x = data[15:0];
      REG_SCROLL_Y: cfg_scroll_y = data[15:0];
      REG_LAYER_EN: cfg_enable   = data[0];
      default:      ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_config(input logic wide, input logic [15:0] scr_x,
                              input logic [15:0] scr_y, input logic enable);
    wait_idle();
    reg_write(REG_LAYOUT,   {31'd0, wide});
    reg_write(REG_SCROLL_X, {16'd0, scr_x});
    reg_write(REG_SCROLL_Y, {16'd0, scr_y});
    reg_write(REG_LAYER_EN, {31'd0, enable});
  endtask

  // Scroll values biased toward the ends of the range and small offsets
  function automatic logic [15:0] pick_scroll();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'($urandom_range(0, 63));
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration (tall, no scroll, layer on) plus the ignored action
  task automatic test_reset_defaults();
    fetch_pixel(8'd0, 8'd0);
    fetch_pixel(8'd255, 8'd223);
    send_item(random_item(ACT_NONE));
    fetch_pixel(8'd0, 8'd0);
  endtask

  // Extreme indexes, words and pens; top tile code with flip and transparent pen
  task automatic test_field_extremes();
    in_item_t it;
    it = random_item(ACT_MAP_WR);
    it.map_index = '0;
    it.map_word  = '0;
    send_item(it);
    it.map_index = '1;
    it.map_word  = '1;
    send_item(it);
    it = random_item(ACT_PEN_WR);
    it.pen_address = '0;
    it.pen_value   = '0;
    send_item(it);
    // (0,15): tile code 2047, colour 15, flipped -> reads the very last pen entry
    write_tile_at(8'd0, 8'd15, 16'hffff);
    write_pen_at(8'd0, 8'd15, 4'hf);
    fetch_pixel(8'd0, 8'd15);
    write_pen_at(8'd0, 8'd15, 4'h0);
    fetch_pixel(8'd0, 8'd15);
  endtask

  // One pen per colour pair, either side of its front-half boundary
  task automatic test_front_priority();
    logic [3:0] colours [4] = '{4'd0, 4'd3, 4'd4, 4'd6};
    logic [3:0] pens    [4] = '{4'd11, 4'd8, 4'd3, 4'd0};
    for (int k = 0; k < 4; k++) begin
      write_tile_at(8'd40, 8'd100, {1'b0, colours[k], 11'($urandom)});
      write_pen_at(8'd40, 8'd100, pens[k]);
      fetch_pixel(8'd40, 8'd100);
    end
  endtask

  // Both layouts, scroll at both ends, layer disabled
  task automatic test_scroll_and_layout();
    apply_config(1'b1, 16'hffff, 16'hffff, 1'b1);
    fetch_pixel(8'd0, 8'd0);
    fetch_pixel(8'd255, 8'd255);
    apply_config(1'b0, 16'hffff, 16'h0000, 1'b0);
    fetch_pixel(8'd0, 8'd0);
    fetch_pixel(8'd255, 8'd223);
    apply_config(1'b1, 16'h0000, 16'h0000, 1'b0);
    fetch_pixel(8'd128, 8'd240);
    apply_config(1'b0, 16'h0000, 16'hffff, 1'b1);
    fetch_pixel(8'd17, 8'd255);
  endtask

  // Mostly pixel requests around a hot spot so tiles and pens get reused and
  // rewritten; the rest is scattered writes and the ignored action.
  task automatic run_traffic(input int count);
    int         stop_at;
    int         pick;
    logic [7:0] hot_x;
    logic [7:0] hot_y;
    logic [7:0] sx;
    logic [7:0] sy;
    stop_at = requests_sent + count;
    hot_x   = 8'($urandom);
    hot_y   = 8'($urandom_range(0, 223));
    while (requests_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 1) == 0) begin
        sx = hot_x + 8'($urandom_range(0, 31));
        sy = hot_y + 8'($urandom_range(0, 31));
      end else begin
        sx = 8'($urandom);
        sy = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 223))
                                         : 8'($urandom_range(224, 255));
      end
      if (pick < 55) begin
        fetch_pixel(sx, sy);
      end else if (pick < 67) begin
        write_tile_at(sx, sy, 16'($urandom));
      end else if (pick < 77) begin
        write_pen_at(sx, sy, 4'($urandom));
      end else if (pick < 87) begin
        send_item(random_item(ACT_MAP_WR));
      end else if (pick < 95) begin
        send_item(random_item(ACT_PEN_WR));
      end else begin
        send_item(random_item(ACT_NONE));
      end
    end
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int c = 0; c < CHUNKS; c++) begin
      apply_config(1'($urandom), pick_scroll(), pick_scroll(),
                   $urandom_range(0, 4) != 0);
      run_traffic(TRAFFIC_REQS / (3 * CHUNKS));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver back-pressure, redrawn every clock
  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);

  // Each accepted pixel must match the oldest prediction field by field
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("[%0t] pixel with nothing pending: got %p", $realtime, out_data);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.palette_index !== want.palette_index ||
            out_data.back_opaque   !== want.back_opaque   ||
            out_data.front_opaque  !== want.front_opaque) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("[%0t] pixel mismatch: expected %p got %p", $realtime, want, out_data);
        end
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_front_priority();
    test_scroll_and_layout();
    test_random_traffic(34, 81);
    test_random_traffic(81, 34);
    test_random_traffic(0, 0);
    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
